// ===== rtl/tcow_pkg.sv =====
package tcow_pkg;

  localparam int unsigned GlyphWidthDef = 6;
  localparam int unsigned LineLimitDef  = 122;
  localparam int unsigned PageCountDef  = 8;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned GlyphCount = 96;

  localparam logic [1:0] OP_PUT_CHAR   = 2'd0;
  localparam logic [1:0] OP_SET_CURSOR = 2'd1;
  localparam logic [1:0] OP_SET_SCROLL = 2'd2;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_FIRST   = 8'h20;
  localparam logic [7:0] CHAR_LAST    = 8'h7E;
  localparam logic [6:0] GLYPH_UNPRINTABLE = 7'h5F;

  localparam logic [7:0] BYTE_CMD_PAIR   = 8'h80;
  localparam logic [7:0] BYTE_CMD_ONLY   = 8'h00;
  localparam logic [7:0] BYTE_SET_OFFSET = 8'hD3;
  localparam logic [7:0] BYTE_PAGE_BASE  = 8'hB0;
  localparam logic [7:0] BYTE_COL_HIGH   = 8'h10;
  localparam logic [7:0] BYTE_DATA_MARK  = 8'h40;

  typedef enum logic [1:0] {
    SCR_OFF     = 2'd0,
    SCR_ARMED   = 2'd1,
    SCR_REQUEST = 2'd2,
    SCR_ACTIVE  = 2'd3
  } scroll_e;

  // byte position within one character transfer
  typedef enum logic [4:0] {
    ST_OFF_CMD   = 5'd0,
    ST_OFF_CODE  = 5'd1,
    ST_OFF_VAL   = 5'd2,
    ST_PAGE_CTL  = 5'd3,
    ST_PAGE      = 5'd4,
    ST_COL_L_CTL = 5'd5,
    ST_COL_L     = 5'd6,
    ST_COL_H_CTL = 5'd7,
    ST_COL_H     = 5'd8,
    ST_MARK      = 5'd9,
    ST_GLYPH0    = 5'd10,
    ST_GLYPH1    = 5'd11,
    ST_GLYPH2    = 5'd12,
    ST_GLYPH3    = 5'd13,
    ST_GLYPH4    = 5'd14,
    ST_GLYPH5    = 5'd15,
    ST_SPACER    = 5'd16
  } step_e;

  // one printable character, classified and ready to be sent
  typedef struct packed {
    logic       has_offset;
    logic [2:0] page;
    logic [6:0] column;
    logic [6:0] glyph_idx;
    logic       invert;
  } job_t;

  // first column byte in the top bits
  localparam logic [47:0] GLYPH_ROM [GlyphCount] = '{
    48'h000000000000, 48'h00005F000000, 48'h000003000300, 48'h14741F741F14,
    48'h0046E95F4930, 48'h47350F745271, 48'h384F49577840, 48'h000003000000,
    48'h00003CC30000, 48'h0000C33C0000, 48'h0005020F0205, 48'h0008083E0808,
    48'h0000E0E00000, 48'h001010100000, 48'h000060600000, 48'h0080601C0300,
    48'h3E5149453E00, 48'h0042417F4040, 48'h004261514946, 48'h004149493600,
    48'h181412117F10, 48'h004F49493100, 48'h003E4B494930, 48'h000141310D03,
    48'h00364D495936, 48'h00464949291E, 48'h000066660000, 48'h0000E6E60000,
    48'h000018244200, 48'h002828282828, 48'h004224180000, 48'h000058090700,
    48'h7C83383C211F, 48'h00701E111E70, 48'h007F49494936, 48'h003E63414100,
    48'h007F4141633E, 48'h007F49494900, 48'h007F09090900, 48'h3C6341497900,
    48'h007F08087F00, 48'h0041417F4141, 48'h004141413F00, 48'h007F08364100,
    48'h007F40404000, 48'h7C030C0C037C, 48'h007F0E307F00, 48'h3E634141633E,
    48'h007F09090906, 48'h3E43C1613E00, 48'h007F09192640, 48'h004649494931,
    48'h0001017F0101, 48'h003F4040403F, 48'h000738403807, 48'h0F701838700F,
    48'h41621C1C6241, 48'h010204780402, 48'h004171494701, 48'h0000FF818100,
    48'h0000031C6080, 48'h000000FF0000, 48'h000601060000, 48'h000000000000,
    48'h000000000000, 48'h00304A4A6A7C, 48'h007F4642423C, 48'h003C46424200,
    48'h003C4242227F, 48'h003C6A4A4A4C, 48'h04047F040400, 48'hFC9292924E02,
    48'h007F02027E00, 48'h0042427E4000, 48'h00020202FE00, 48'h007F18244200,
    48'h0040407F4000, 48'h007E027E027E, 48'h007E02027E00, 48'h003C4242423C,
    48'h00FE4642423C, 48'h003C424222FE, 48'h007E02020600, 48'h004C4A523200,
    48'h02027F424200, 48'h007E40407E00, 48'h000E3040300E, 48'h003E601C307C,
    48'h426618186642, 48'h000EB0601806, 48'h0042724E4200, 48'h1010FF810000,
    48'h000000FF0000, 48'h000081FF1010, 48'h180818101800, 48'hFFF94DB21E00
  };

endpackage

// ===== rtl/tcow_front.sv =====
module tcow_front #(
  parameter int unsigned GlyphWidth = tcow_pkg::GlyphWidthDef,
  parameter int unsigned LineLimit  = tcow_pkg::LineLimitDef,
  parameter int unsigned PageCount  = tcow_pkg::PageCountDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_wr_en_i,
  input  logic          cfg_wr_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    opcode_i,
  input  logic [7:0]    char_code_i,
  input  logic [2:0]    target_page_i,
  input  logic [6:0]    target_column_i,
  input  logic          scroll_enable_i,
  output logic          push_o,
  output tcow_pkg::job_t job_o,
  input  logic          full_i
);
  import tcow_pkg::*;

  logic [2:0] page_q, page_d;
  logic [6:0] col_q, col_d;
  scroll_e    scr_q, scr_d;
  logic       invert_q;

  logic       accept;
  logic       is_put, is_break, is_print;
  logic [6:0] glyph_idx;
  scroll_e    scr_mid, scr_wrap;
  logic [3:0] page_inc;
  logic [2:0] page_wrap;
  logic [7:0] col_sum;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & in_ready_o;

  assign is_put   = (opcode_i == OP_PUT_CHAR);
  assign is_break = (char_code_i == CHAR_NEWLINE) || (char_code_i == CHAR_TAB);
  assign is_print = is_put & ~is_break;

  assign glyph_idx = ((char_code_i < CHAR_FIRST) || (char_code_i > CHAR_LAST)) ?
                     GLYPH_UNPRINTABLE : 7'(char_code_i - CHAR_FIRST);

  // a pending offset request is served by this character before any wrap
  assign scr_mid = (is_print && scr_q == SCR_REQUEST) ? SCR_ACTIVE : scr_q;

  assign page_inc = {1'b0, page_q} + 4'd1;
  assign col_sum  = {1'b0, col_q} + 8'(GlyphWidth);

  always_comb begin
    scr_wrap  = (scr_mid == SCR_ACTIVE) ? SCR_REQUEST : scr_mid;
    page_wrap = page_inc[2:0];
    if (page_inc >= 4'(PageCount)) begin
      page_wrap = '0;
      if (scr_wrap == SCR_ARMED) begin
        scr_wrap = SCR_REQUEST;
      end
    end
  end

  always_comb begin
    page_d = page_q;
    col_d  = col_q;
    scr_d  = scr_q;
    if (accept) begin
      unique case (opcode_i)
        OP_SET_CURSOR: begin
          page_d = target_page_i;
          col_d  = target_column_i;
        end
        OP_SET_SCROLL: begin
          scr_d = scroll_enable_i ? SCR_ARMED : SCR_OFF;
        end
        OP_PUT_CHAR: begin
          if (is_break || col_sum > 8'(LineLimit)) begin
            page_d = page_wrap;
            col_d  = '0;
            scr_d  = scr_wrap;
          end else begin
            col_d = col_sum[6:0];
            scr_d = scr_mid;
          end
        end
        default: ;
      endcase
    end
  end

  assign push_o           = accept & is_print;
  assign job_o.has_offset = (scr_q == SCR_REQUEST);
  assign job_o.page       = page_q;
  assign job_o.column     = col_q;
  assign job_o.glyph_idx  = glyph_idx;
  assign job_o.invert     = invert_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q   <= '0;
      col_q    <= '0;
      scr_q    <= SCR_OFF;
      invert_q <= 1'b0;
    end else begin
      page_q <= page_d;
      col_q  <= col_d;
      scr_q  <= scr_d;
      if (cfg_wr_en_i) begin
        invert_q <= cfg_wr_data_i;
      end
    end
  end

endmodule

// ===== rtl/tcow_queue.sv =====
module tcow_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcow_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output tcow_pkg::job_t head_o
);
  import tcow_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

endmodule

// ===== rtl/tcow_back.sv =====
module tcow_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  tcow_pkg::job_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           transfer_end_o,
  output logic           last_o
);
  import tcow_pkg::*;

  step_e       step_q, step_d, cur_step;
  logic        out_valid_q;
  logic [7:0]  byte_q, byte_d;
  logic        end_q, end_d;
  logic        last_q, last_d;
  logic        out_free, fire;
  logic [47:0] row;
  logic [7:0]  mask;
  logic [7:0]  offset_val;

  assign out_free = ~out_valid_q | out_ready_i;
  assign fire     = out_free & ~empty_i;

  // a character with no pending offset starts at the page command
  assign cur_step = (step_q == ST_OFF_CMD && !head_i.has_offset) ? ST_PAGE_CTL : step_q;

  assign row        = GLYPH_ROM[head_i.glyph_idx];
  assign mask       = {8{head_i.invert}};
  assign offset_val = {2'b00, head_i.page, 3'b000} + 8'd8;

  always_comb begin
    byte_d = '0;
    end_d  = 1'b0;
    last_d = 1'b0;
    unique case (cur_step) inside
      ST_OFF_CMD:  byte_d = BYTE_CMD_ONLY;
      ST_OFF_CODE: byte_d = BYTE_SET_OFFSET;
      ST_OFF_VAL: begin
        byte_d = offset_val;
        end_d  = 1'b1;
      end
      ST_PAGE_CTL, ST_COL_L_CTL, ST_COL_H_CTL: byte_d = BYTE_CMD_PAIR;
      ST_PAGE:     byte_d = BYTE_PAGE_BASE | {5'd0, head_i.page};
      ST_COL_L:    byte_d = {4'd0, head_i.column[3:0]};
      ST_COL_H:    byte_d = BYTE_COL_HIGH | {5'd0, head_i.column[6:4]};
      ST_MARK:     byte_d = BYTE_DATA_MARK;
      ST_GLYPH0:   byte_d = row[47:40] ^ mask;
      ST_GLYPH1:   byte_d = row[39:32] ^ mask;
      ST_GLYPH2:   byte_d = row[31:24] ^ mask;
      ST_GLYPH3:   byte_d = row[23:16] ^ mask;
      ST_GLYPH4:   byte_d = row[15:8] ^ mask;
      ST_GLYPH5:   byte_d = row[7:0] ^ mask;
      ST_SPACER: begin
        byte_d = mask;
        end_d  = 1'b1;
        last_d = 1'b1;
      end
      default: ;
    endcase
  end

  assign pop_o  = fire & (cur_step == ST_SPACER);
  assign step_d = pop_o ? ST_OFF_CMD : step_e'(cur_step + 5'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_OFF_CMD;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        step_q <= step_d;
      end
      if (out_free) begin
        out_valid_q <= ~empty_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q <= byte_d;
      end_q  <= end_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = byte_q;
  assign transfer_end_o = end_q;
  assign last_o         = last_q;

endmodule

// ===== rtl/text_console_oled_writer.sv =====
// Character terminal for a page-addressed 128x64 OLED, 6x8 font.
// Input stream: one command per beat; s_axis_tuser carries the opcode
// (put character, set cursor, set scroll mode), s_axis_tdata the operands.
// Output stream: one display bus byte per beat; m_axis_tuser marks the last
// byte of a bus transfer, m_axis_tlast the last byte caused by a command.
// A printable character gives 14 bytes, or 17 when a scroll offset transfer
// goes first; newline, tab, set cursor and set scroll give no bytes.
// The front takes a command every cycle while the two-entry job queue has
// room and updates cursor and scroll state at once. The back sends one byte
// per cycle while the receiver keeps m_axis_tready high; a printable character
// is written into the job queue, and its bytes then leave through the output register.
// When the receiver stalls, the output register holds its byte and the
// queue fills; s_axis_tready drops while two characters sit in the queue,
// the one being sent included.
// cfg_wr_en_i writes the invert bit; write it only while the block is idle.
// Reset puts the cursor at page 0, column 0, scroll off, invert off, and
// empties the queue.
module text_console_oled_writer #(
  parameter int unsigned GlyphWidth = tcow_pkg::GlyphWidthDef,
  parameter int unsigned LineLimit  = tcow_pkg::LineLimitDef,
  parameter int unsigned PageCount  = tcow_pkg::PageCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic        cfg_wr_data_i,   // invert
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // char_code, target_page, target_column, scroll_enable
  input  logic [1:0]  s_axis_tuser,    // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,    // out_byte
  output logic        m_axis_tuser,    // transfer_end
  output logic        m_axis_tlast     // last
);
  import tcow_pkg::*;

  logic push, full, pop, empty;
  job_t push_job, head_job;

  tcow_front #(
    .GlyphWidth(GlyphWidth),
    .LineLimit (LineLimit),
    .PageCount (PageCount)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .opcode_i       (s_axis_tuser),
    .char_code_i    (s_axis_tdata[7:0]),
    .target_page_i  (s_axis_tdata[10:8]),
    .target_column_i(s_axis_tdata[17:11]),
    .scroll_enable_i(s_axis_tdata[18]),
    .push_o         (push),
    .job_o          (push_job),
    .full_i         (full)
  );

  tcow_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_job_i(push_job),
    .full_o    (full),
    .pop_i     (pop),
    .empty_o   (empty),
    .head_o    (head_job)
  );

  tcow_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head_job),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata),
    .transfer_end_o(m_axis_tuser),
    .last_o        (m_axis_tlast)
  );

endmodule
